FILE: rtl/core/suffix_radix_number_parser_defines.svh
// Assertion helpers used by the parser RTL.
`ifndef SUFFIX_RADIX_NUMBER_PARSER_DEFINES_SVH
`define SUFFIX_RADIX_NUMBER_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define SRNP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SRNP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/srnp_pkg.sv
package srnp_pkg;

  localparam int unsigned ValueWidth = 16;
  localparam int unsigned CharWidth  = 8;
  localparam int unsigned RadixWidth = 2;

  typedef logic [CharWidth-1:0]  char_t;
  typedef logic [ValueWidth-1:0] value_t;
  typedef logic [RadixWidth-1:0] radix_t;

  localparam char_t CH_HEX_SUFFIX = 8'h68;  // 'h'
  localparam char_t CH_BIN_SUFFIX = 8'h69;  // 'i'
  localparam char_t CH_LF   = 8'd10;
  localparam char_t CH_CR   = 8'd13;
  localparam char_t CH_DIG0 = 8'd48;
  localparam char_t CH_DIG1 = 8'd49;
  localparam char_t CH_DIG9 = 8'd57;
  localparam char_t CH_UPA  = 8'd65;
  localparam char_t CH_UPF  = 8'd70;
  localparam char_t CH_LOA  = 8'd97;
  localparam char_t CH_LOF  = 8'd102;

  localparam radix_t RADIX_DEC = 2'd0;
  localparam radix_t RADIX_HEX = 2'd1;
  localparam radix_t RADIX_BIN = 2'd2;
  localparam radix_t RADIX_UNUSED = 2'd3;

  typedef struct packed {
    char_t char_code;
    logic  last_char;
  } char_item_t;

  typedef struct packed {
    value_t value;
    logic   ok;
    radix_t radix;
  } result_item_t;

endpackage

FILE: rtl/core/srnp_stream_if.sv
interface srnp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/suffix_radix_number_parser.sv
// Number literal parser: takes one ASCII character per transfer (last_char marks the
// end) and returns one result per literal. The final character picks the radix:
// 'h' hexadecimal, 'i' binary, anything else decimal and counted as a digit. CR and
// LF are skipped; values wrap at 16 bits; ok drops at the first bad digit. One
// character is accepted every cycle, but the final character stalls while the result
// register is still held. A result goes from the input register through the accumulator
// update into the result register; the combinational accumulator update sets the rate.
`include "suffix_radix_number_parser_defines.svh"

module suffix_radix_number_parser (
  input logic          clk,
  input logic          rst,
  srnp_stream_if.sink   chars,
  srnp_stream_if.source results
);
  import srnp_pkg::*;

  logic  s1_valid;
  char_t s1_char;
  logic  s1_last;
  logic  s1_go;

  value_t hex_value, dec_value, bin_value;
  logic   hex_good, dec_good, bin_good;
  value_t hex_value_next, dec_value_next, bin_value_next;
  logic   hex_good_next, dec_good_next, bin_good_next;

  logic         out_valid;
  result_item_t out_item;
  result_item_t out_item_next;

  logic       skip;
  logic       dec_ok, hex_ok, bin_ok;
  logic [3:0] hex_digit;

  logic lit_done;
  logic s1_stall;
  logic acc_clear;

  // The final character stalls only when the result register is still held.
  assign s1_go        = s1_valid && (!s1_last || !out_valid || results.ready);
  assign chars.ready  = !s1_valid || s1_go;
  assign results.valid   = out_valid;
  assign results.payload = out_item;

  assign lit_done  = s1_go && s1_last;
  assign s1_stall  = s1_valid && !s1_go;
  assign acc_clear = (hex_value == '0) && (dec_value == '0) && (bin_value == '0) &&
                     hex_good && dec_good && bin_good;

  always_comb begin
    skip   = (s1_char == CH_LF) || (s1_char == CH_CR);
    dec_ok = s1_char inside {[CH_DIG0:CH_DIG9]};
    bin_ok = (s1_char == CH_DIG0) || (s1_char == CH_DIG1);
    hex_ok = 1'b1;
    hex_digit = 4'd0;
    if (s1_char inside {[CH_DIG0:CH_DIG9]}) begin
      hex_digit = s1_char[3:0];
    end else if (s1_char inside {[CH_UPA:CH_UPF]} || s1_char inside {[CH_LOA:CH_LOF]}) begin
      hex_digit = 4'd9 + {1'b0, s1_char[2:0]};
    end else begin
      hex_ok = 1'b0;
    end

    dec_value_next = dec_value;
    dec_good_next  = dec_good;
    hex_value_next = hex_value;
    hex_good_next  = hex_good;
    bin_value_next = bin_value;
    bin_good_next  = bin_good;
    if (!skip) begin
      if (dec_good) begin
        if (dec_ok) begin
          dec_value_next = (dec_value << 3) + (dec_value << 1)
                           + {{(ValueWidth-4){1'b0}}, s1_char[3:0]};
        end else begin
          dec_good_next = 1'b0;
        end
      end
      if (hex_good) begin
        if (hex_ok) begin
          hex_value_next = {hex_value[ValueWidth-5:0], hex_digit};
        end else begin
          hex_good_next = 1'b0;
        end
      end
      if (bin_good) begin
        if (bin_ok) begin
          bin_value_next = {bin_value[ValueWidth-2:0], s1_char[0]};
        end else begin
          bin_good_next = 1'b0;
        end
      end
    end

    if (s1_char == CH_HEX_SUFFIX) begin
      out_item_next = '{value: hex_value, ok: hex_good, radix: RADIX_HEX};
    end else if (s1_char == CH_BIN_SUFFIX) begin
      out_item_next = '{value: bin_value, ok: bin_good, radix: RADIX_BIN};
    end else begin
      out_item_next = '{value: dec_value_next, ok: dec_good_next, radix: RADIX_DEC};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (chars.ready) begin
      s1_valid <= chars.valid;
    end
    if (chars.ready && chars.valid) begin
      s1_char <= chars.payload.char_code;
      s1_last <= chars.payload.last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hex_value <= '0;
      dec_value <= '0;
      bin_value <= '0;
      hex_good  <= 1'b1;
      dec_good  <= 1'b1;
      bin_good  <= 1'b1;
    end else if (s1_go) begin
      if (s1_last) begin
        hex_value <= '0;
        dec_value <= '0;
        bin_value <= '0;
        hex_good  <= 1'b1;
        dec_good  <= 1'b1;
        bin_good  <= 1'b1;
      end else begin
        hex_value <= hex_value_next;
        dec_value <= dec_value_next;
        bin_value <= bin_value_next;
        hex_good  <= hex_good_next;
        dec_good  <= dec_good_next;
        bin_good  <= bin_good_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_last) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_go && s1_last) begin
      out_item <= out_item_next;
    end
  end

  `SRNP_ASSERT_NEXT(a_result_follows_last, clk, rst, lit_done, out_valid, "no result for literal")
  `SRNP_ASSERT_NEXT(a_clear_after_literal, clk, rst, lit_done, acc_clear, "state not cleared")
  `SRNP_ASSERT_NOW(a_stalled_stage_blocks, clk, rst, s1_stall, !chars.ready, "stage overrun")
  `SRNP_ASSERT_NOW(a_radix_code, clk, rst, out_valid, out_item.radix <= RADIX_BIN, "bad radix")

endmodule

FILE: verif/suffix_radix_number_parser_tb.sv
`timescale 1ns / 100ps

module suffix_radix_number_parser_tb;
  import srnp_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned LongHoldCycles = 120;

  logic clk;
  logic rst;

  srnp_stream_if #(.payload_t(char_item_t))   char_bus ();
  srnp_stream_if #(.payload_t(result_item_t)) result_bus ();

  suffix_radix_number_parser i_dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (char_bus.sink),
    .results (result_bus.source)
  );

  char_item_t   char_queue[$];
  result_item_t expected_results[$];

  // shadow accumulators, one per radix
  value_t hex_acc = '0;
  value_t dec_acc = '0;
  value_t bin_acc = '0;
  logic   hex_ok  = 1'b1;
  logic   dec_ok  = 1'b1;
  logic   bin_ok  = 1'b1;

  int unsigned chars_pushed   = 0;
  int unsigned chars_accepted = 0;
  int unsigned literals_checked = 0;
  int unsigned radix_seen[3] = '{0, 0, 0};
  int unsigned bad_literals = 0;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;

  logic idle_en  = 1'b0;
  logic hold_req = 1'b0;
  logic hold_taken;
  int unsigned hold_left;
  int unsigned src_gap;
  int unsigned snk_gap;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic char_t digit_char(radix_t rx);
    int d;
    case (rx)
      RADIX_BIN: return $urandom_range(0, 1) ? CH_DIG1 : CH_DIG0;
      RADIX_HEX: begin
        d = $urandom_range(0, 15);
        if (d < 10) return char_t'(CH_DIG0 + d);
        if ($urandom_range(0, 1)) return char_t'(CH_UPA + d - 10);
        return char_t'(CH_LOA + d - 10);
      end
      default: return char_t'(CH_DIG0 + $urandom_range(0, 9));
    endcase
  endfunction

  task automatic push_char(input char_t c, input logic is_last);
    char_item_t ci;
    ci.char_code = c;
    ci.last_char = is_last;
    char_queue = {char_queue, ci};
    chars_pushed++;
  endtask

  task automatic push_literal(input string s);
    for (int k = 0; k < s.len(); k++) push_char(char_t'(s[k]), k == s.len() - 1);
  endtask

  // mostly well-formed literals; some carry CR/LF or a stray bad char, some are pure noise
  task automatic push_random_literal();
    int len;
    radix_t rsel;
    char_t c;
    if ($urandom_range(0, 9) == 0) begin
      len = $urandom_range(1, 6);
      for (int k = 0; k < len; k++)
        push_char(char_t'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      return;
    end
    rsel = radix_t'($urandom_range(0, 2));
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 15) == 0) c = $urandom_range(0, 1) ? CH_CR : CH_LF;
      else if ($urandom_range(0, 19) == 0) c = char_t'($urandom_range(0, 255));
      else c = digit_char(rsel);
      push_char(c, 1'b0);
    end
    case (rsel)
      RADIX_HEX: c = CH_HEX_SUFFIX;
      RADIX_BIN: c = CH_BIN_SUFFIX;
      default: begin
        case ($urandom_range(0, 9))
          0: c = $urandom_range(0, 1) ? CH_CR : CH_LF;
          1: c = char_t'($urandom_range(0, 255));
          default: c = digit_char(RADIX_DEC);
        endcase
      end
    endcase
    push_char(c, 1'b1);
  endtask

  // runs one accepted character through the shadow accumulators
  task automatic absorb_char(input char_item_t ci);
    char_t c;
    logic skip;
    logic suffix;
    result_item_t r;
    c = ci.char_code;
    skip = (c == CH_LF) || (c == CH_CR);
    suffix = ci.last_char && (c == CH_HEX_SUFFIX || c == CH_BIN_SUFFIX);
    if (!skip && !suffix && dec_ok) begin
      if (c >= CH_DIG0 && c <= CH_DIG9) dec_acc = value_t'(dec_acc * 10 + (c - CH_DIG0));
      else dec_ok = 1'b0;
    end
    // the final character only ever feeds decimal
    if (!skip && !ci.last_char) begin
      if (hex_ok) begin
        if (c >= CH_DIG0 && c <= CH_DIG9) hex_acc = {hex_acc[11:0], 4'(c - CH_DIG0)};
        else if (c >= CH_UPA && c <= CH_UPF) hex_acc = {hex_acc[11:0], 4'(c - CH_UPA + 10)};
        else if (c >= CH_LOA && c <= CH_LOF) hex_acc = {hex_acc[11:0], 4'(c - CH_LOA + 10)};
        else hex_ok = 1'b0;
      end
      if (bin_ok) begin
        if (c == CH_DIG0 || c == CH_DIG1) bin_acc = {bin_acc[14:0], c == CH_DIG1};
        else bin_ok = 1'b0;
      end
    end
    if (ci.last_char) begin
      if (c == CH_HEX_SUFFIX) begin
        r.value = hex_acc;
        r.ok    = hex_ok;
        r.radix = RADIX_HEX;
      end else if (c == CH_BIN_SUFFIX) begin
        r.value = bin_acc;
        r.ok    = bin_ok;
        r.radix = RADIX_BIN;
      end else begin
        r.value = dec_acc;
        r.ok    = dec_ok;
        r.radix = RADIX_DEC;
      end
      expected_results = {expected_results, r};
      hex_acc = '0;
      dec_acc = '0;
      bin_acc = '0;
      hex_ok  = 1'b1;
      dec_ok  = 1'b1;
      bin_ok  = 1'b1;
    end
  endtask

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  task automatic wait_drained();
    while (char_queue.size() != 0 || char_bus.valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // char driver
  always @(posedge clk) begin
    if (rst) begin
      char_bus.valid <= 1'b0;
      src_gap <= 0;
    end else if (!char_bus.valid || char_bus.ready) begin
      if (src_gap != 0) begin
        src_gap <= src_gap - 1;
        char_bus.valid <= 1'b0;
      end else if (char_queue.size() == 0) begin
        char_bus.valid <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        src_gap <= $urandom_range(0, 2);
        char_bus.valid <= 1'b0;
      end else begin
        char_bus.valid   <= 1'b1;
        char_bus.payload <= char_queue.pop_front();
      end
    end
  end

  // result ready, with short random stalls and one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      result_bus.ready <= 1'b0;
      hold_taken <= 1'b0;
      hold_left <= 0;
      snk_gap <= 0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= LongHoldCycles;
      result_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      result_bus.ready <= 1'b0;
    end else if (snk_gap != 0) begin
      snk_gap <= snk_gap - 1;
      result_bus.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      snk_gap <= $urandom_range(0, 2);
      result_bus.ready <= 1'b0;
    end else begin
      result_bus.ready <= 1'b1;
    end
  end

  // monitor: check results first, then predict from the char transfer of the same edge
  always @(posedge clk) begin
    result_item_t exp_r;
    result_item_t got_r;
    if (!rst) begin
      if (result_bus.valid && result_bus.ready) begin
        got_r = result_bus.payload;
        if (expected_results.size() == 0) begin
          note_failure($sformatf("unexpected result value %h ok %b radix %0d",
                                 got_r.value, got_r.ok, got_r.radix));
        end else begin
          exp_r = expected_results.pop_front();
          literals_checked++;
          if (exp_r.radix <= RADIX_BIN) radix_seen[exp_r.radix]++;
          if (!exp_r.ok) bad_literals++;
          if (got_r.value !== exp_r.value || got_r.ok !== exp_r.ok ||
              got_r.radix !== exp_r.radix)
            note_failure($sformatf(
              "literal %0d: expected value %h ok %b radix %0d, got value %h ok %b radix %0d",
              literals_checked, exp_r.value, exp_r.ok, exp_r.radix,
              got_r.value, got_r.ok, got_r.radix));
        end
      end
      if (char_bus.valid && char_bus.ready) begin
        chars_accepted++;
        absorb_char(char_bus.payload);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (char_bus.valid && char_bus.ready) || (result_bus.valid && result_bus.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
               quiet_cycles, expected_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned mark;
    rst = 1'b1;
    char_bus.valid = 1'b0;
    char_bus.payload = '0;
    result_bus.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: bare suffixes, mixed-case hex, binary, decimal wrap,
    // out-of-range codes, CR as final char, LF mid-literal, bad digits
    idle_en = 1'b1;
    push_literal("h");
    push_literal("i");
    push_literal("aF9h");
    push_literal("101i");
    push_literal("65536");
    push_char(8'h00, 1'b0);
    push_char(8'hFF, 1'b0);
    push_char(CH_CR, 1'b1);
    push_literal("1\n2");
    push_literal("2i");
    push_literal("3gh");
    wait_drained();

    // random with both sides stalling; long result hold-off while chars keep coming
    mark = chars_pushed;
    while (chars_pushed < 600) push_random_literal();
    while (chars_accepted < mark + 150) @(negedge clk);
    hold_req = 1'b1;
    wait_drained();

    while (chars_pushed < 1200) push_random_literal();
    wait_drained();

    // tail at full rate
    idle_en = 1'b0;
    while (chars_pushed < 1500) push_random_literal();
    wait_drained();
    repeat (10) @(posedge clk);

    if (expected_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", expected_results.size()));
    $display("Sent %0d chars; checked %0d literals (dec %0d, hex %0d, bin %0d), %0d bad-digit",
             chars_accepted, literals_checked, radix_seen[RADIX_DEC], radix_seen[RADIX_HEX],
             radix_seen[RADIX_BIN], bad_literals);
    $display("Failures: %0d", fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
